FILE: sv/bahc_pkg.sv
// Shared types, constants and helper functions for the basic auth header checker.
// No dependencies; used by the top level and the checker.
package bahc_pkg;

  localparam int unsigned BAHC_MAX_DECODED = 64;  // default decoded-byte limit
  localparam int unsigned HEADER_LEN       = 21;  // "Authorization: Basic "
  localparam int unsigned CRED_DEPTH       = 64;  // credential store entries
  localparam int unsigned CRED_AW          = 6;   // credential store address bits
  localparam int unsigned CRED_W           = 8;   // credential byte width

  // input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  // characters that end the header value
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_PAD = 8'h3D;  // '='

  typedef enum logic [2:0] {
    VERD_OK       = 3'd0,
    VERD_NO_PASS  = 3'd1,
    VERD_NO_HDR   = 3'd2,
    VERD_BAD_CHAR = 3'd3,
    VERD_OVERFLOW = 3'd4,
    VERD_EMPTY    = 3'd5,
    VERD_LENGTH   = 3'd6,
    VERD_CONTENT  = 3'd7
  } verdict_t;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_DECODE = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  // character of "Authorization: Basic " at a position
  function automatic logic [7:0] hdr_char(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = "A";
      5'd1:    ch = "u";
      5'd2:    ch = "t";
      5'd3:    ch = "h";
      5'd4:    ch = "o";
      5'd5:    ch = "r";
      5'd6:    ch = "i";
      5'd7:    ch = "z";
      5'd8:    ch = "a";
      5'd9:    ch = "t";
      5'd10:   ch = "i";
      5'd11:   ch = "o";
      5'd12:   ch = "n";
      5'd13:   ch = ":";
      5'd14:   ch = " ";
      5'd15:   ch = "B";
      5'd16:   ch = "a";
      5'd17:   ch = "s";
      5'd18:   ch = "i";
      5'd19:   ch = "c";
      5'd20:   ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // base64 alphabet lookup: {valid, 6-bit value}
  function automatic logic [6:0] b64_decode(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= "A" && c <= "Z") begin
      r = {1'b1, 6'(c - 8'd65)};
    end else if (c >= "a" && c <= "z") begin
      r = {1'b1, 6'(c - 8'd71)};
    end else if (c >= "0" && c <= "9") begin
      r = {1'b1, 6'(c + 8'd4)};
    end else if (c == "+") begin
      r = {1'b1, 6'd62};
    end else if (c == "/") begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

FILE: sv/bahc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instanced for the expected credential store.
module bahc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/basic_auth_header_checker_unit.sv
// Top level of the HTTP basic auth header checker: header search, base64
// decode, credential compare. Depends on bahc_pkg and bahc_ram.
//
// Usage
//   Input channel (in_valid/in_ready): opcode 0 loads data_byte into the
//   credential store at cred_index; opcode 1 streams one request character.
//   A request transfer with end_of_request set produces exactly one result
//   transfer on the output channel (accepted, verdict, decoded_count).
//   APB port: register 0 (addr 0) credential_length, register 1 (addr 4)
//   password_present. Write only while the block is idle. pready is tied high.
// Timing
//   One input transfer per cycle while in_ready is high. The edge that takes the final
//   request byte updates the parse state, loads stage B and issues the RAM read;
//   the output register then registers the verdict, unless a stall holds stage B.
// Stalls
//   The output register holds a verdict until out_ready while bytes keep
//   flowing; in_ready drops only while a second verdict waits behind it.
// Reset
//   rst_n (synchronous) clears the parse state, config registers and the
//   output valid. The credential RAM is not cleared; load it before use.
module basic_auth_header_checker_unit
  import bahc_pkg::*;
#(
  parameter int unsigned MAX_DECODED = BAHC_MAX_DECODED
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [5:0]  in_cred_index,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_request,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [2:0]  out_verdict,
  output logic [6:0]  out_decoded_count,
  // APB config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // decoded-byte counter width, and a common width for compares
  localparam int unsigned DW = $clog2(MAX_DECODED + 1);
  localparam int unsigned CW = (DW > 7) ? DW : 7;
  localparam logic [4:0] HDR_LAST = 5'(HEADER_LEN - 1);

  // ---------------- config registers ----------------
  logic [6:0] cred_len_r;
  logic       pw_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_len_r <= 7'd0;
      pw_r       <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        pw_r <= pwdata[0];
      end else begin
        cred_len_r <= pwdata[6:0];
      end
    end
  end

  assign prdata = paddr[2] ? {31'd0, pw_r} : {25'd0, cred_len_r};

  // ---------------- handshake ----------------
  logic in_xfer, is_req, step, stall;

  assign in_xfer = in_valid & in_ready;
  assign is_req  = (in_opcode == OP_REQ);
  assign step    = in_xfer & is_req;

  // ---------------- stage A: parse state ----------------
  logic [4:0]    hpos_r,  hpos_nxt,  hpos_c;
  phase_t        phase_r, phase_nxt, phase_c;
  logic [13:0]   acc_r,   acc_nxt,   acc_c;
  logic [2:0]    bc_r,    bc_nxt,    bc_c;
  logic [DW-1:0] dec_r,   dec_nxt,   dec_c;
  verdict_t      err_r,   err_nxt,   err_c;
  logic          ended_r, ended_nxt, ended_c;

  logic [6:0]    b64;
  logic [3:0]    bc_sum;
  logic          byte_en;
  logic [13:0]   acc_sh;
  logic          term;

  assign b64  = b64_decode(in_data_byte);
  assign term = (in_data_byte == CH_CR) || (in_data_byte == CH_LF) ||
                (in_data_byte == CH_SP) || (in_data_byte == CH_NUL) ||
                (in_data_byte == CH_PAD);

  always_comb begin
    hpos_c  = hpos_r;
    phase_c = phase_r;
    acc_c   = acc_r;
    bc_c    = bc_r;
    dec_c   = dec_r;
    err_c   = err_r;
    ended_c = ended_r;
    byte_en = 1'b0;
    bc_sum  = {1'b0, bc_r} + 4'd6;
    if (!ended_r) begin
      case (phase_r)
        PH_SEARCH: begin
          if (in_data_byte == hdr_char(hpos_r)) begin
            if (hpos_r == HDR_LAST) begin
              hpos_c  = 5'd0;
              phase_c = PH_DECODE;
            end else begin
              hpos_c = hpos_r + 5'd1;
            end
          end else begin
            // header has no self-overlap: restart, possibly on this byte
            hpos_c = (in_data_byte == hdr_char(5'd0)) ? 5'd1 : 5'd0;
          end
        end
        PH_DECODE: begin
          if (term) begin
            phase_c = PH_DONE;
          end else if (!b64[6]) begin
            err_c   = VERD_BAD_CHAR;
            phase_c = PH_DONE;
          end else begin
            acc_c = {acc_r[7:0], b64[5:0]};
            if (bc_sum >= 4'd8) begin
              bc_c = 3'(bc_sum - 4'd8);
              if (dec_r >= DW'(MAX_DECODED)) begin
                err_c   = VERD_OVERFLOW;
                phase_c = PH_DONE;
              end else begin
                byte_en = 1'b1;
                dec_c   = dec_r + DW'(1);
              end
            end else begin
              bc_c = bc_sum[2:0];
            end
          end
        end
        default: begin
        end
      endcase
      if (in_data_byte == CH_NUL) begin
        ended_c = 1'b1;
      end
    end
  end

  assign acc_sh = acc_c >> bc_c;

  // verdict from everything but the content compare
  logic [CW-1:0] dec_c_ext, dec_r_ext;
  verdict_t      base_v;
  logic          chk_content;

  assign dec_c_ext = CW'(dec_c);
  assign dec_r_ext = CW'(dec_r);

  always_comb begin
    chk_content = 1'b0;
    if (!pw_r) begin
      base_v = VERD_NO_PASS;
    end else if (phase_c == PH_SEARCH) begin
      base_v = VERD_NO_HDR;
    end else if (err_c != VERD_OK) begin
      base_v = err_c;
    end else if (dec_c == '0) begin
      base_v = VERD_EMPTY;
    end else if (dec_c_ext != CW'(cred_len_r)) begin
      base_v = VERD_LENGTH;
    end else begin
      base_v      = VERD_OK;
      chk_content = 1'b1;
    end
  end

  // per-request state: cleared after the verdict byte
  always_comb begin
    hpos_nxt  = hpos_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    bc_nxt    = bc_r;
    dec_nxt   = dec_r;
    err_nxt   = err_r;
    ended_nxt = ended_r;
    if (step) begin
      if (in_end_of_request) begin
        hpos_nxt  = 5'd0;
        phase_nxt = PH_SEARCH;
        acc_nxt   = 14'd0;
        bc_nxt    = 3'd0;
        dec_nxt   = '0;
        err_nxt   = VERD_OK;
        ended_nxt = 1'b0;
      end else begin
        hpos_nxt  = hpos_c;
        phase_nxt = phase_c;
        acc_nxt   = acc_c;
        bc_nxt    = bc_c;
        dec_nxt   = dec_c;
        err_nxt   = err_c;
        ended_nxt = ended_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpos_r  <= 5'd0;
      phase_r <= PH_SEARCH;
      acc_r   <= 14'd0;
      bc_r    <= 3'd0;
      dec_r   <= '0;
      err_r   <= VERD_OK;
      ended_r <= 1'b0;
    end else begin
      hpos_r  <= hpos_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      bc_r    <= bc_nxt;
      dec_r   <= dec_nxt;
      err_r   <= err_nxt;
      ended_r <= ended_nxt;
    end
  end

  // ---------------- credential store ----------------
  // Loads write at transfer time, reads issue at transfer time; one transfer
  // per cycle, so a write and a read never share a cycle.
  logic [CRED_W-1:0] ram_rdata;

  bahc_ram #(
    .WIDTH (CRED_W),
    .DEPTH (CRED_DEPTH)
  ) u_cred_ram (
    .clk   (clk),
    .we    (in_xfer & ~is_req),
    .waddr (in_cred_index),
    .wdata (in_data_byte),
    .re    (step & byte_en),
    .raddr (dec_r_ext[CRED_AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- stage B: compare and verdict ----------------
  logic       sb_valid_r, sb_valid_nxt;
  logic       sb_last_r, sb_byte_r, sb_oob_r, sb_chk_r;
  logic [7:0] sb_b_r;
  verdict_t   sb_base_r;
  logic [6:0] sb_cnt_r;
  logic       diff_r, diff_nxt, diff_all, cmp;
  verdict_t   final_v;
  logic       emit;

  assign stall    = sb_valid_r & sb_last_r & out_valid & ~out_ready;
  assign in_ready = ~stall;

  // index past the store counts as a difference
  assign cmp      = sb_byte_r & (sb_oob_r | (ram_rdata != sb_b_r));
  assign diff_all = diff_r | cmp;
  assign final_v  = sb_chk_r ? (diff_all ? VERD_CONTENT : VERD_OK) : sb_base_r;
  assign emit     = sb_valid_r & sb_last_r & ~stall;

  always_comb begin
    sb_valid_nxt = stall ? sb_valid_r : step;
    diff_nxt     = diff_r;
    if (sb_valid_r && !stall) begin
      diff_nxt = sb_last_r ? 1'b0 : diff_all;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
      diff_r     <= 1'b0;
    end else begin
      sb_valid_r <= sb_valid_nxt;
      diff_r     <= diff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sb_last_r <= in_end_of_request;
      sb_byte_r <= byte_en;
      sb_oob_r  <= (dec_r_ext >= CW'(CRED_DEPTH));
      sb_b_r    <= acc_sh[7:0];
      sb_base_r <= base_v;
      sb_chk_r  <= chk_content;
      sb_cnt_r  <= dec_c_ext[6:0];
    end
  end

  // ---------------- output register ----------------
  logic       out_valid_r, out_valid_nxt;
  logic       out_acc_r;
  verdict_t   out_verd_r;
  logic [6:0] out_cnt_r;

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_acc_r  <= (final_v == VERD_OK);
      out_verd_r <= final_v;
      out_cnt_r  <= sb_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_verdict       = out_verd_r;
  assign out_decoded_count = out_cnt_r;

endmodule

FILE: sv/bahc_checker.sv
// Port-level checker for basic_auth_header_checker_unit, bound to the top level.
// Depends on bahc_pkg for verdict codes.
module bahc_checker
  import bahc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [2:0]  out_verdict,
  input logic [6:0]  out_decoded_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
                                $stable(out_decoded_count) && $stable(out_accepted))
    else $error("result changed while stalled");

  // accepted flag agrees with verdict
  a_acc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_verdict == VERD_OK)))
    else $error("accepted disagrees with verdict");

  // empty verdict only with no decoded bytes; ok never with none
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERD_EMPTY) |-> out_decoded_count == 7'd0)
    else $error("empty verdict with decoded bytes");

  a_ok_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERD_OK) |-> out_decoded_count != 7'd0)
    else $error("ok verdict with no decoded bytes");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind basic_auth_header_checker_unit bahc_checker u_bahc_checker (.*);
